### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CNE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define CNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cne_pkg.sv
`timescale 1ns / 1ps

package cne_pkg;

    // Default capacity of the line stores in pixels.
    localparam int MAX_WIDTH_DEF = 1024;

    // Widths of the configuration registers.
    localparam int THR_W = 8;
    localparam int FW_W  = 11;
    localparam int FH_W  = 12;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd100;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = 11'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 12'd480;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    // Request kinds on the input channel.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // One input request.
    typedef struct packed {
        logic       func;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic edge_res;
        logic row_end;
        logic frame_end;
    } out_item_t;

    // Write enables towards the line stores.
    typedef struct packed {
        logic pix;
        logic flag_a;
        logic flag_b;
    } lstore_we_t;

    // True when any channel of the two pixels differs by more than the threshold.
    // Pixels are packed as {red, green, blue}.
    function automatic logic pix_differs(input logic [23:0] p, input logic [23:0] q,
                                         input logic [THR_W-1:0] thr);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        logic       any;
        any = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            a = p[8*k +: 8];
            b = q[8*k +: 8];
            d = (a > b) ? (a - b) : (b - a);
            any = any | (d > thr);
        end
        return any;
    endfunction

endpackage

### rtl/cne_line_store.sv
`timescale 1ns / 1ps

module cne_line_store import cne_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  lstore_we_t    we,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_addr_b,
    input  logic [23:0]   pix_wdata,
    input  logic [1:0]    a_wdata,
    input  logic          b_wdata,
    output logic [23:0]   pix_rdata,
    output logic [1:0]    a_rdata,
    output logic          b_rdata
);

    // Pixels of the row kept, and the two halves of its edge flags:
    // flag A holds the vertical and last-column part in bit 0, and in bit 1
    // a mark that a right neighbour followed in that row; flag B holds the
    // difference to the right neighbour.
    logic [23:0] pix_mem [DEPTH];
    logic [1:0]  a_mem [DEPTH];
    logic        b_mem [DEPTH];

    logic [23:0] pix_rdata_reg;
    logic [1:0]  a_rdata_reg;
    logic        b_rdata_reg;

    // Pixel store, read before write.
    always_ff @(posedge clk)
    begin
        if (we.pix)
        begin
            pix_mem[wr_addr] <= pix_wdata;
        end
        if (rd_en)
        begin
            pix_rdata_reg <= pix_mem[rd_addr];
        end
    end

    // Flag A store, read before write.
    always_ff @(posedge clk)
    begin
        if (we.flag_a)
        begin
            a_mem[wr_addr] <= a_wdata;
        end
        if (rd_en)
        begin
            a_rdata_reg <= a_mem[rd_addr];
        end
    end

    // Flag B store; a read of the entry written in the same cycle sees the
    // new value (two-pixel rows wrap straight back onto it).
    always_ff @(posedge clk)
    begin
        if (we.flag_b)
        begin
            b_mem[wr_addr_b] <= b_wdata;
        end
        if (rd_en)
        begin
            if (we.flag_b && (wr_addr_b == rd_addr))
            begin
                b_rdata_reg <= b_wdata;
            end
            else
            begin
                b_rdata_reg <= b_mem[rd_addr];
            end
        end
    end

    assign pix_rdata = pix_rdata_reg;
    assign a_rdata   = a_rdata_reg;
    assign b_rdata   = b_rdata_reg;

endmodule

### rtl/color_neighbor_edge_map.sv
`timescale 1ns / 1ps
// A result passes through the second stage and then the output register.
// Throughput: one request per cycle unless stalled; one read and one write port per store.
// Reset (rst_n, asynchronous, active low) clears the counters, the drain flag and the
// pipeline, and loads threshold 100, width 640, height 480. The line stores are not cleared.

module color_neighbor_edge_map import cne_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    // Configuration registers.
    logic [THR_W-1:0] threshold_reg;
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;

    // Front-end control state.
    logic [CW-1:0]    col_reg, col_next;
    logic [FH_W-1:0]  row_reg, row_next;
    logic             draining_reg, draining_next;

    // Second stage.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_res_reg;
    logic             s1_drain_reg;
    logic             s1_last_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [23:0]      s1_pix_reg;
    logic [23:0]      prev_pix_reg;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg;

    logic             in_acc;
    logic             enter;
    logic             enter_res;
    logic [LW-1:0]    fw_ext;
    logic [LW-1:0]    fw_eff;
    logic [LW-1:0]    col_last_idx;
    logic [FH_W-1:0]  row_last_idx;
    logic             col_last;
    logic             row_last;
    logic [23:0]      in_pix;

    logic             s1_go;
    lstore_we_t       ls_we;
    logic [23:0]      ls_pix_rd;
    logic [1:0]       ls_a_rd;
    logic             ls_b_rd;
    logic             above;
    logic             v_diff;
    logic             d_diff;

    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[THR_W-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size: width clamped to [2, MAX_WIDTH], height at least one.
    always_comb
    begin
        fw_ext = LW'(frame_width_reg);
        if (fw_ext < LW'(2))
        begin
            fw_eff = LW'(2);
        end
        else if (fw_ext > LW'(MAX_WIDTH))
        begin
            fw_eff = LW'(MAX_WIDTH);
        end
        else
        begin
            fw_eff = fw_ext;
        end
        col_last_idx = fw_eff - LW'(1);
        row_last_idx = (frame_height_reg == '0) ? '0 : frame_height_reg - FH_W'(1);
    end

    assign col_last = (LW'(col_reg) >= col_last_idx);
    assign row_last = (row_reg >= row_last_idx);
    assign in_pix   = {in_item.red, in_item.green, in_item.blue};

    // Handshake: the second stage only blocks when its result cannot leave.
    assign s1_go    = s1_valid_reg && (!s1_res_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_acc   = in_valid && !in_stall;

    // Raster counters and drain flag, advanced by pixels outside a drain and drains in one.
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        enter         = 1'b0;
        enter_res     = 1'b0;
        if (in_acc)
        begin
            if (in_item.func == FUNC_PIXEL)
            begin
                if (!draining_reg)
                begin
                    enter     = 1'b1;
                    enter_res = (row_reg != '0);
                    if (col_last)
                    begin
                        col_next = '0;
                        if (row_last)
                        begin
                            row_next      = '0;
                            draining_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + FH_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            else if (draining_reg)
            begin
                enter     = 1'b1;
                enter_res = 1'b1;
                if (col_last)
                begin
                    col_next      = '0;
                    draining_next = 1'b0;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
        end
    end

    // Second-stage occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (enter)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Second-stage payload, loaded together with the line store read.
    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_res_reg   <= enter_res;
            s1_drain_reg <= (in_item.func == FUNC_DRAIN);
            s1_last_reg  <= col_last;
            s1_col_reg   <= col_reg;
            s1_pix_reg   <= in_pix;
        end
        if (s1_go && !s1_drain_reg)
        begin
            prev_pix_reg <= s1_pix_reg;
        end
    end

    // Line stores: read at the request's column, written from the second stage.
    assign ls_we.pix    = s1_go && !s1_drain_reg;
    assign ls_we.flag_a = s1_go && !s1_drain_reg;
    assign ls_we.flag_b = s1_go && !s1_drain_reg && (s1_col_reg != '0);

    cne_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (enter),
        .rd_addr   (col_reg),
        .we        (ls_we),
        .wr_addr   (s1_col_reg),
        .wr_addr_b (s1_col_reg - CW'(1)),
        .pix_wdata (s1_pix_reg),
        .a_wdata   ({!s1_last_reg, v_diff | (s1_last_reg & d_diff)}),
        .b_wdata   (d_diff),
        .pix_rdata (ls_pix_rd),
        .a_rdata   (ls_a_rd),
        .b_rdata   (ls_b_rd)
    );

    // Edge decision: flag of the pixel above, plus the vertical compare and the
    // compare with the left neighbour that feeds the flags of this row. The
    // right-neighbour half only counts when that row went on past this column,
    // which keeps it right when the width is narrowed in mid-frame.
    assign above  = ls_a_rd[0] | (ls_a_rd[1] & ls_b_rd);
    assign v_diff = s1_res_reg && !s1_drain_reg
                    && pix_differs(ls_pix_rd, s1_pix_reg, threshold_reg);
    assign d_diff = (s1_col_reg != '0) && pix_differs(prev_pix_reg, s1_pix_reg, threshold_reg);

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_res_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_res_reg)
        begin
            out_item_reg.edge_res  <= above | v_diff;
            out_item_reg.row_end   <= s1_last_reg;
            out_item_reg.frame_end <= s1_last_reg & s1_drain_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/cne_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cne_checker import cne_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // A frame ends only on the last pixel of a row.
    `CNE_ASSERT(a_frame_end_row, clk, rst_n, out_valid |-> (!out_item.frame_end || out_item.row_end), "frame_end without row_end")

    // A stalled result stays offered and unchanged.
    `CNE_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_item)), "stalled result changed")

    // The input side is held back only by a result that cannot leave.
    `CNE_ASSERT(a_in_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without output back-pressure")

    // No result is offered in the cycle after reset.
    `CNE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result offered right after reset")

endmodule

bind color_neighbor_edge_map cne_checker u_cne_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

### test/tb_color_neighbor_edge_map.sv
`timescale 1ns / 1ps

module tb_color_neighbor_edge_map;
    import cne_pkg::*;

    localparam int LINE_MAX = MAX_WIDTH_DEF;
    localparam int unsigned WHOLE_FRAME = 32'hffff_ffff;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_THRESHOLD;
    logic [11:0] cfg_data = '0;

    // Register copies and line stores of the edge predictor.
    logic [THR_W-1:0] thr_q = THRESHOLD_RST;
    logic [FW_W-1:0]  width_q = FRAME_WIDTH_RST;
    logic [FH_W-1:0]  height_q = FRAME_HEIGHT_RST;
    logic [23:0]      line_pix [LINE_MAX];
    logic             line_flag [LINE_MAX];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    bit               draining_q = 1'b0;

    in_item_t    pending_requests [$];
    out_item_t   expected_edges [$];

    bit          failed = 1'b0;
    int unsigned real_items = 0;
    logic        long_hold = 1'b0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    int unsigned results_seen = 0;
    logic [23:0] base_px = '0;
    int unsigned spread = 0;
    bit          add_noise = 1'b0;

    color_neighbor_edge_map uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock with a period of 20 ns.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_q < 2)
            return 2;
        if (width_q > LINE_MAX)
            return LINE_MAX;
        return 32'(width_q);
    endfunction

    function automatic int unsigned active_height();
        return (height_q == 0) ? 1 : 32'(height_q);
    endfunction

    // Two pixels differ when any channel is further apart than the threshold.
    function automatic logic pixels_differ(logic [23:0] a, logic [23:0] b);
        int chan_gap;
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            chan_gap = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            if (chan_gap < 0)
                chan_gap = -chan_gap;
            if (chan_gap > int'(thr_q))
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Works out the result, if any, that an accepted request causes.
    function automatic void predict_edge_map(in_item_t req);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        logic        at_end;
        logic [23:0] pix;
        logic        below;
        logic        side;
        out_item_t   res;
        w = active_width();
        h = active_height();
        c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        at_end = (c >= w - 1);
        if (req.func == FUNC_PIXEL)
        begin
            if (draining_q)
                return;
            pix = {req.red, req.green, req.blue};
            below = 1'b0;
            side = 1'b0;
            if (row_pos > 0)
            begin
                below = pixels_differ(line_pix[c], pix);
                res.edge_res = line_flag[c] | below;
                res.row_end = at_end;
                res.frame_end = 1'b0;
                expected_edges.push_back(res);
            end
            if (c > 0)
            begin
                side = pixels_differ(line_pix[c-1], pix);
                line_flag[c-1] = line_flag[c-1] | side;
            end
            line_pix[c] = pix;
            line_flag[c] = below | (at_end & side);
            if (at_end)
            begin
                col_pos = 0;
                if (row_pos >= h - 1)
                begin
                    row_pos = 0;
                    draining_q = 1'b1;
                end
                else
                    row_pos++;
            end
            else
                col_pos = c + 1;
        end
        else
        begin
            if (!draining_q)
                return;
            res.edge_res = line_flag[c];
            res.row_end = at_end;
            res.frame_end = at_end;
            expected_edges.push_back(res);
            if (at_end)
            begin
                col_pos = 0;
                draining_q = 1'b0;
            end
            else
                col_pos = c + 1;
        end
    endfunction

    function automatic void push_req(logic func, logic [23:0] rgb, bit counted);
        in_item_t req;
        req.func = func;
        req.red = rgb[23:16];
        req.green = rgb[15:8];
        req.blue = rgb[7:0];
        pending_requests.push_back(req);
        if (counted)
            real_items++;
    endfunction

    // Pixels cluster around a base colour that jumps now and then.
    function automatic logic [23:0] make_pixel();
        logic [23:0] p;
        if ($urandom_range(0, 7) == 0)
            base_px = 24'($urandom);
        for (int k = 0; k < 3; k++)
            p[8*k +: 8] = base_px[8*k +: 8] + 8'($urandom_range(0, spread));
        return p;
    endfunction

    // Queues up to budget requests of what is left of the current frame, plus noise requests.
    function automatic void feed_frame(int unsigned budget);
        int unsigned w;
        int unsigned pix_left;
        int unsigned drain_left;
        w = active_width();
        if (draining_q)
        begin
            pix_left = 0;
            drain_left = (col_pos >= w - 1) ? 1 : w - col_pos;
        end
        else
        begin
            pix_left = (col_pos >= w - 1) ? 1 : w - col_pos;
            if (row_pos < active_height() - 1)
                pix_left += (active_height() - 1 - row_pos) * w;
            drain_left = w;
        end
        while (pix_left != 0 && budget != 0)
        begin
            if (add_noise && $urandom_range(0, 15) == 0)
                push_req(FUNC_DRAIN, 24'($urandom), 1'b0);
            push_req(FUNC_PIXEL, make_pixel(), 1'b1);
            pix_left--;
            budget--;
        end
        while (drain_left != 0 && budget != 0)
        begin
            if (add_noise && $urandom_range(0, 15) == 0)
                push_req(FUNC_PIXEL, 24'($urandom), 1'b0);
            push_req(FUNC_DRAIN, 24'($urandom), 1'b1);
            drain_left--;
            budget--;
        end
    endfunction

    function automatic int unsigned pick_threshold();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_height();
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    endfunction

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[11:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    thr_q = value[THR_W-1:0];
            CFG_FRAME_WIDTH:  width_q = value[FW_W-1:0];
            CFG_FRAME_HEIGHT: height_q = value[FH_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_config(int unsigned thr, int unsigned w, int unsigned h);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
    endtask

    // Waits until every request is taken and every result is back, then lets the
    // pipeline settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_edges.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic void check_edge_result(out_item_t got);
        out_item_t want;
        if (expected_edges.size() == 0)
        begin
            $display("%0t: result %b arrived with none expected", $time, got);
            failed = 1'b1;
            return;
        end
        want = expected_edges.pop_front();
        if (got.edge_res !== want.edge_res)
        begin
            $display("%0t: edge_res expected %b, got %b", $time, want.edge_res, got.edge_res);
            failed = 1'b1;
        end
        if (got.row_end !== want.row_end)
        begin
            $display("%0t: row_end expected %b, got %b", $time, want.row_end, got.row_end);
            failed = 1'b1;
        end
        if (got.frame_end !== want.frame_end)
        begin
            $display("%0t: frame_end expected %b, got %b", $time, want.frame_end,
                     got.frame_end);
            failed = 1'b1;
        end
    endfunction

    // Request driver: predicts on acceptance, then offers the next request after its gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_edge_map(in_item);
            if (!(in_valid && in_stall))
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    in_item <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = !tx_burst;
                    tx_gap = (tx_burst || long_hold) ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted result and stalls at random, with an
    // occasional long hold-off that backs the block up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            long_hold <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_edge_result(out_item);
                results_seen++;
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
                if (results_seen % 400 == 100)
                    hold_left = 120;
            end
            else if (rx_wait != 0)
                rx_wait--;
            if (hold_left != 0)
                hold_left--;
            out_stall <= (rx_wait != 0) || (hold_left != 0);
            long_hold <= (hold_left != 0);
        end
    end

    // Stimulus: directed frames, the size extremes, then random frames.
    initial
    begin
        int unsigned start_count;
        int unsigned frame_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-row frame with out-of-range width and height, plus ignored requests.
        set_config(0, 1, 0);
        push_req(FUNC_DRAIN, 24'h000000, 1'b0);
        push_req(FUNC_PIXEL, 24'h000000, 1'b1);
        push_req(FUNC_PIXEL, 24'hffffff, 1'b1);
        push_req(FUNC_PIXEL, 24'hffffff, 1'b0);
        push_req(FUNC_DRAIN, 24'hffffff, 1'b1);
        push_req(FUNC_DRAIN, 24'h000000, 1'b1);
        wait_idle();

        // Channel differences just above and exactly at the threshold.
        set_config(254, 3, 2);
        push_req(FUNC_PIXEL, 24'hffffff, 1'b1);
        push_req(FUNC_PIXEL, 24'h000000, 1'b1);
        push_req(FUNC_PIXEL, 24'h01ff01, 1'b1);
        push_req(FUNC_PIXEL, 24'hff00ff, 1'b1);
        push_req(FUNC_PIXEL, 24'hfefefe, 1'b1);
        push_req(FUNC_PIXEL, 24'h000000, 1'b1);
        repeat (3) push_req(FUNC_DRAIN, 24'h000000, 1'b1);
        wait_idle();

        // Width and height reduced in mid-frame below the current column and row.
        set_config(100, 4, 3);
        spread = 255;
        feed_frame(6);
        wait_idle();
        set_config(255, 2, 1);
        feed_frame(WHOLE_FRAME);
        wait_idle();

        // Widest line: a width register beyond the store acts as the full store.
        // The drain is cut short by narrowing the width once it has begun.
        spread = 60;
        set_config(pick_threshold(), 2047, 1);
        feed_frame(LINE_MAX + 1);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 2);
        feed_frame(WHOLE_FRAME);
        wait_idle();

        // Tallest height register, cut short in mid-frame.
        set_config(pick_threshold(), 2, 4095);
        feed_frame(20);
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 3);
        feed_frame(WHOLE_FRAME);
        wait_idle();

        // Random frames, a quarter of them reconfigured part way through.
        add_noise = 1'b1;
        start_count = real_items;
        while (real_items - start_count < 300)
        begin
            set_config(pick_threshold(),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
                       ($urandom_range(0, 29) == 0) ? $urandom_range(13, 64) :
                       $urandom_range(2, 12),
                       pick_height());
            spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 40);
            base_px = 24'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                frame_len = active_width() * (active_height() + 1);
                feed_frame($urandom_range(1, frame_len - 1));
                wait_idle();
                set_config(pick_threshold(), $urandom_range(0, active_width()),
                           pick_height());
            end
            feed_frame(WHOLE_FRAME);
            wait_idle();
        end

        wait_idle();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/cne_pkg.sv
rtl/cne_line_store.sv
rtl/color_neighbor_edge_map.sv
rtl/cne_checker.sv
test/tb_color_neighbor_edge_map.sv
